>>> hdl/apa_pkg.sv
package apa_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned LEASE_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 2;
    // Output word: address, lease, status, padded to whole bytes.
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [LEASE_W-1:0] LEASE_OFFER = 16'd3600;
    localparam logic [LEASE_W-1:0] LEASE_NONE  = 16'd0;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY = 2'd2;

    localparam logic [ADDR_W-1:0] NETWORK_RESET = 32'd0;
    localparam logic [ADDR_W-1:0] MASK_RESET    = 32'd255;
    localparam logic [ADDR_W-1:0] GATEWAY_RESET = 32'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_STEP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wrapped;
    } t_step_res;

endpackage

>>> hdl/apa_table.sv
module apa_table #(
    parameter int unsigned DEPTH = apa_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [apa_pkg::ADDR_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [apa_pkg::ADDR_W-1:0] o_rdata
);

    logic [apa_pkg::ADDR_W-1:0] r_mem [DEPTH];
    logic [apa_pkg::ADDR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/apa_step.sv
module apa_step (
    input  logic [apa_pkg::ADDR_W-1:0] i_cand,
    input  logic [apa_pkg::ADDR_W-1:0] i_network,
    input  logic [apa_pkg::ADDR_W-1:0] i_mask,
    output apa_pkg::t_step_res         o_res
);

    // Octets go from the lowest up; out-of-range octets fall back to the
    // network octet and the carry moves on to the next one.
    always_comb begin
        logic       carried;
        logic [7:0] h;
        logic [7:0] v;
        logic [7:0] n;
        logic [7:0] nv;
        carried = 1'b0;
        o_res.addr = i_cand;
        for (int oct = 0; oct < 4; oct++) begin
            h  = i_mask[oct*8 +: 8];
            v  = i_cand[oct*8 +: 8];
            n  = i_network[oct*8 +: 8];
            nv = v;
            if (h != 8'd0 && !carried) begin
                if (v < n || (v - n) >= h) begin
                    nv = n;
                end else begin
                    nv = v + 8'd1;
                    carried = 1'b1;
                end
            end
            o_res.addr[oct*8 +: 8] = nv;
        end
        o_res.wrapped = !carried;
    end

endmodule

>>> hdl/address_pool_allocator_top.sv
// Channel   Direction  Word
// s_axis    in         tdata[31:0] client_address
// m_axis    out        tdata address, lease_seconds, status; tuser kind; tlast last
// cfg       in         index 0 network, 1 host mask, 2 gateway; data 32 bits
//
// A registration is written to the table if it has room, and its result word
// then waits for tready. A request gives three offers. Each candidate is checked
// against the gateway in ST_CHECK and, when the table is not empty, scanned in
// ST_SCAN through the single read port of the reserved table; a rejected candidate
// then goes through ST_STEP, where the shared octet step unit gives the next one.
// Reset is synchronous and active low; the table holds no valid bits.
// Input is not taken while an item is at work or its result word waits.
module address_pool_allocator_top #(
    parameter int unsigned TABLE_DEPTH = apa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [apa_pkg::ADDR_W-1:0]     i_s_axis_tdata,   // [31:0] client_address
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [apa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] address,
                                                             // [47:32] lease_seconds,
                                                             // [49:48] status, rest zero
    output logic                           o_m_axis_tuser,   // [0] kind
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [apa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apa_pkg::ADDR_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    apa_pkg::t_state r_state, n_state;
    logic [apa_pkg::ADDR_W-1:0] r_cand, n_cand;
    logic [apa_pkg::ADDR_W-1:0] r_net, n_net;
    logic [apa_pkg::ADDR_W-1:0] r_mask, n_mask;
    logic [apa_pkg::ADDR_W-1:0] r_gw, n_gw;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [1:0]    r_offer, n_offer;
    logic          r_wrap, n_wrap;

    logic                             r_out_valid, n_out_valid;
    logic                             r_out_kind, n_out_kind;
    logic [apa_pkg::ADDR_W-1:0]       r_out_addr, n_out_addr;
    logic [apa_pkg::LEASE_W-1:0]      r_out_lease, n_out_lease;
    logic [apa_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic                             r_out_last, n_out_last;

    logic                       tbl_we;
    logic                       tbl_re;
    logic [apa_pkg::ADDR_W-1:0] tbl_rdata;
    apa_pkg::t_step_res         step;

    apa_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_re    (tbl_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    apa_step u_step (
        .i_cand    (r_cand),
        .i_network (r_net),
        .i_mask    (r_mask),
        .o_res     (step)
    );

    assign o_s_axis_tready = (r_state == apa_pkg::ST_IDLE) && !r_out_valid;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {6'd0, r_out_status, r_out_lease, r_out_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apa_pkg::ST_IDLE;
            r_cand      <= apa_pkg::NETWORK_RESET;
            r_net       <= apa_pkg::NETWORK_RESET;
            r_mask      <= apa_pkg::MASK_RESET;
            r_gw        <= apa_pkg::GATEWAY_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_offer     <= 2'd0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cand      <= n_cand;
            r_net       <= n_net;
            r_mask      <= n_mask;
            r_gw        <= n_gw;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_offer     <= n_offer;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_addr   <= n_out_addr;
        r_out_lease  <= n_out_lease;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_cand       = r_cand;
        n_net        = r_net;
        n_mask       = r_mask;
        n_gw         = r_gw;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_offer      = r_offer;
        n_wrap       = r_wrap;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_addr   = r_out_addr;
        n_out_lease  = r_out_lease;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        tbl_we       = 1'b0;
        tbl_re       = 1'b0;

        case (r_state)
            apa_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid && o_s_axis_tready) begin
                    if (i_s_axis_tdata != '0) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = apa_pkg::KIND_ACK;
                        n_out_addr  = i_s_axis_tdata;
                        n_out_lease = apa_pkg::LEASE_NONE;
                        n_out_last  = 1'b1;
                        if (r_count < DEPTH_C) begin
                            tbl_we       = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_out_status = apa_pkg::STATUS_OK;
                        end else begin
                            n_out_status = apa_pkg::STATUS_TABLE_FULL;
                        end
                        n_state = apa_pkg::ST_OUT;
                    end else begin
                        n_offer = 2'd0;
                        n_wrap  = 1'b0;
                        n_state = apa_pkg::ST_CHECK;
                    end
                end
            end
            apa_pkg::ST_CHECK: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (r_cand == r_gw) begin
                    n_state = apa_pkg::ST_STEP;
                end else if (r_count == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = apa_pkg::KIND_OFFER;
                    n_out_addr   = r_cand;
                    n_out_lease  = apa_pkg::LEASE_OFFER;
                    n_out_status = apa_pkg::STATUS_OK;
                    n_out_last   = (r_offer == 2'd2);
                    n_cand       = step.addr;
                    n_state      = apa_pkg::ST_OUT;
                end else begin
                    n_state = apa_pkg::ST_SCAN;
                end
            end
            apa_pkg::ST_SCAN: begin
                // Reads are issued one entry a cycle; each compare uses the registered read data, flagged by r_pend.
                tbl_re = (r_idx < r_count);
                n_pend = tbl_re;
                n_idx  = r_idx + CW'(tbl_re);
                if (r_pend && tbl_rdata == r_cand) begin
                    n_state = apa_pkg::ST_STEP;
                end else if (!r_pend && !tbl_re) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = apa_pkg::KIND_OFFER;
                    n_out_addr   = r_cand;
                    n_out_lease  = apa_pkg::LEASE_OFFER;
                    n_out_status = apa_pkg::STATUS_OK;
                    n_out_last   = (r_offer == 2'd2);
                    n_cand       = step.addr;
                    n_state      = apa_pkg::ST_OUT;
                end
            end
            apa_pkg::ST_STEP: begin
                n_cand  = step.addr;
                n_state = apa_pkg::ST_CHECK;
                if (step.wrapped) begin
                    if (r_wrap) begin
                        // Second full wrap in one search: nothing left to offer.
                        n_out_valid  = 1'b1;
                        n_out_kind   = apa_pkg::KIND_OFFER;
                        n_out_addr   = '0;
                        n_out_lease  = apa_pkg::LEASE_NONE;
                        n_out_status = apa_pkg::STATUS_EXHAUSTED;
                        n_out_last   = (r_offer == 2'd2);
                        n_state      = apa_pkg::ST_OUT;
                    end else begin
                        n_wrap = 1'b1;
                    end
                end
            end
            apa_pkg::ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = apa_pkg::ST_IDLE;
                    end else begin
                        n_offer = r_offer + 2'd1;
                        n_wrap  = 1'b0;
                        n_state = apa_pkg::ST_CHECK;
                    end
                end
            end
            default: begin
                n_state = apa_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                apa_pkg::CFG_NETWORK: begin
                    n_net  = i_cfg_data;
                    n_cand = i_cfg_data;
                end
                apa_pkg::CFG_MASK: begin
                    n_mask = i_cfg_data;
                end
                apa_pkg::CFG_GATEWAY: begin
                    n_gw = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/apa_chk.sv
module apa_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [apa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                           o_m_axis_tuser,
    input  logic                           o_m_axis_tlast
);

    // A waiting result word holds its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result word changed while stalled");

    // No new input word is taken while a result word waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while result pending");

    // An acknowledgement is a single word run with no lease.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == apa_pkg::KIND_ACK |->
            o_m_axis_tlast && o_m_axis_tdata[47:32] == apa_pkg::LEASE_NONE &&
            o_m_axis_tdata[49:48] != apa_pkg::STATUS_EXHAUSTED)
        else $error("bad acknowledgement word");

    // Offers carry the lease only when good; exhausted offers carry address zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == apa_pkg::KIND_OFFER |->
            (o_m_axis_tdata[49:48] == apa_pkg::STATUS_OK &&
             o_m_axis_tdata[47:32] == apa_pkg::LEASE_OFFER) ||
            (o_m_axis_tdata[49:48] == apa_pkg::STATUS_EXHAUSTED &&
             o_m_axis_tdata[47:32] == apa_pkg::LEASE_NONE &&
             o_m_axis_tdata[31:0] == 32'd0))
        else $error("bad offer word");

    // After the final word of a run goes out, the block is ready for input again.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready)
        else $error("not ready after final result");

endmodule

bind address_pool_allocator_top apa_chk u_apa_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
